// ----- sv/bpl_pkg.sv -----
// bracket pair locator package: payload beat types, character codes and kind helpers
package bpl_pkg;

    // position field width
    localparam int POS_W = 16;

    // bracket kinds; KIND_NONE marks a byte that is no bracket
    localparam logic [1:0] KIND_SQUARE = 2'd0;
    localparam logic [1:0] KIND_ROUND  = 2'd1;
    localparam logic [1:0] KIND_BRACE  = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    // mode that enables all three kinds
    localparam logic [1:0] MODE_ANY = 2'd3;

    // result status codes
    localparam logic [1:0] STATUS_FOUND     = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_MODE        = 2'd0;
    localparam logic [1:0] REG_OPEN_LIMIT  = 2'd1;
    localparam logic [1:0] REG_CLOSE_LIMIT = 2'd2;

    // bracket characters
    localparam logic [7:0] CH_SQ_OPEN  = 8'h5B;
    localparam logic [7:0] CH_SQ_CLOSE = 8'h5D;
    localparam logic [7:0] CH_RD_OPEN  = 8'h28;
    localparam logic [7:0] CH_RD_CLOSE = 8'h29;
    localparam logic [7:0] CH_BR_OPEN  = 8'h7B;
    localparam logic [7:0] CH_BR_CLOSE = 8'h7D;

    // input beat
    typedef struct packed {
        logic [7:0]       character;
        logic [POS_W-1:0] position;
        logic             first;
        logic             last;
    } t_in_beat;

    // result beat
    typedef struct packed {
        logic [1:0]       status;
        logic [POS_W-1:0] start_pos;
        logic [POS_W-1:0] end_pos;
    } t_out_beat;

    // kind of an opening bracket
    function automatic logic [1:0] opener_kind(input logic [7:0] ch);
        logic [1:0] k;
        case (ch)
            CH_SQ_OPEN: k = KIND_SQUARE;
            CH_RD_OPEN: k = KIND_ROUND;
            CH_BR_OPEN: k = KIND_BRACE;
            default:    k = KIND_NONE;
        endcase
        return k;
    endfunction

    // kind of a closing bracket
    function automatic logic [1:0] closer_kind(input logic [7:0] ch);
        logic [1:0] k;
        case (ch)
            CH_SQ_CLOSE: k = KIND_SQUARE;
            CH_RD_CLOSE: k = KIND_ROUND;
            CH_BR_CLOSE: k = KIND_BRACE;
            default:     k = KIND_NONE;
        endcase
        return k;
    endfunction

    // kind is a bracket and the mode admits it
    function automatic logic kind_enabled(input logic [1:0] k, input logic [1:0] mode);
        return (k != KIND_NONE) && ((mode == MODE_ANY) || (mode == k));
    endfunction

endpackage

// ----- sv/bracket_pair_locator.sv -----
// bracket pair locator: finds the first outermost balanced bracket pair in a byte stream
//
// Takes one character beat per cycle while the input is not stalled, and registers its
// result (pair found, not found at the last character, or stack overflow) for the output
// channel in the output register, or in the skid register while the output register holds
// an untaken result; at most one result per beat. The stack of open bracket
// kinds lives in a STACK_DEPTH x 2 memory with one write and one registered read per
// cycle: each cycle the memory is read at the entry that will be the top after the
// current beat, so the top is ready for the next beat, and a push to that same entry
// is forwarded around the memory. Stack entries are only read below the fill count,
// so the memory needs no clearing after reset. Results pass through an output register
// and a skid register, so input is stalled only when both hold an untaken result.
// Registers: mode at 0x0, open limit at 0x4, close limit at 0x8; write them while idle.
module bracket_pair_locator #(
    parameter int STACK_DEPTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // character input channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  bpl_pkg::t_in_beat   i_in_data,
    // result output channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output bpl_pkg::t_out_beat  o_out_data,
    // register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import bpl_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // configuration registers
    logic [1:0]       r_mode;
    logic [POS_W-1:0] r_open_limit;
    logic [POS_W-1:0] r_close_limit;

    // search state
    logic [CW-1:0]    r_count;
    logic [POS_W-1:0] r_open_pos;
    logic             r_done;

    // stack memory and its read port
    logic [1:0]       r_stack [STACK_DEPTH];
    logic [1:0]       r_rd_kind;
    logic             r_fwd;
    logic [1:0]       r_fwd_kind;

    // output register and skid
    logic             r_out_valid;
    t_out_beat        r_out;
    logic             r_skid_valid;
    t_out_beat        r_skid;

    // beat processing
    logic             w_in_acc;
    logic             w_out_acc;
    logic             w_cfg_wr;
    logic [1:0]       w_top;
    logic [1:0]       w_ok;
    logic [1:0]       w_ck;
    logic [CW-1:0]    w_count_b;
    logic [POS_W-1:0] w_open_pos_b;
    logic             w_done_b;
    logic             w_push;
    logic             w_res_valid;
    t_out_beat        w_res;
    logic [CW-1:0]    n_count;
    logic [POS_W-1:0] n_open_pos;
    logic             n_done;
    logic [AW-1:0]    w_rd_addr;

    assign w_in_acc  = i_in_valid && !r_skid_valid;
    assign w_out_acc = r_out_valid && !i_out_stall;
    assign w_cfg_wr  = psel && penable && pwrite;

    // top of stack, forwarded when the last beat pushed onto the entry just read
    assign w_top = r_fwd ? r_fwd_kind : r_rd_kind;
    assign w_ok  = opener_kind(i_in_data.character);
    assign w_ck  = closer_kind(i_in_data.character);

    // next search state for the accepted beat
    always_comb begin
        w_count_b    = i_in_data.first ? '0 : r_count;
        w_open_pos_b = i_in_data.first ? '0 : r_open_pos;
        w_done_b     = i_in_data.first ? 1'b0 : r_done;
        n_count      = r_count;
        n_open_pos   = r_open_pos;
        n_done       = r_done;
        w_push       = 1'b0;
        w_res_valid  = 1'b0;
        w_res        = '{status: STATUS_NOT_FOUND, start_pos: '0, end_pos: '0};
        if (w_in_acc) begin
            n_count    = w_count_b;
            n_open_pos = w_open_pos_b;
            n_done     = w_done_b;
            if (!w_done_b) begin
                if (kind_enabled(w_ok, r_mode) && (i_in_data.position <= r_open_limit)) begin
                    if (w_count_b == CW'(STACK_DEPTH)) begin
                        // push onto a full stack
                        w_res_valid = 1'b1;
                        w_res.status = STATUS_OVERFLOW;
                    end else begin
                        w_push  = 1'b1;
                        n_count = w_count_b + CW'(1);
                        if (w_count_b == '0) begin
                            n_open_pos = i_in_data.position;
                        end
                    end
                end else if ((w_count_b != '0) && kind_enabled(w_ck, r_mode) &&
                             (i_in_data.position <= r_close_limit) && (w_top == w_ck)) begin
                    if (w_count_b == CW'(1)) begin
                        // outermost pair closed
                        w_res_valid     = 1'b1;
                        w_res.status    = STATUS_FOUND;
                        w_res.start_pos = w_open_pos_b;
                        w_res.end_pos   = i_in_data.position;
                    end else begin
                        n_count = w_count_b - CW'(1);
                    end
                end
                // end of string without a pair
                if (!w_res_valid && i_in_data.last) begin
                    w_res_valid  = 1'b1;
                    w_res.status = STATUS_NOT_FOUND;
                end
                if (w_res_valid) begin
                    n_done = 1'b1;
                end
            end
        end
    end

    // read the entry that becomes the top after this beat
    assign w_rd_addr = AW'(n_count - CW'(1));

    // stack memory
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_stack[w_count_b[AW-1:0]] <= w_ok;
        end
        r_rd_kind <= r_stack[w_rd_addr];
    end

    // forwarding of a push to the entry being read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else begin
            r_fwd <= w_push;
        end
        r_fwd_kind <= w_ok;
    end

    // search state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_open_pos <= '0;
            r_done     <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_open_pos <= n_open_pos;
            r_done     <= n_done;
        end
    end

    // output register with skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_out_acc) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (w_res_valid) begin
            if (!r_out_valid || w_out_acc) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_out_acc) begin
                r_out <= r_skid;
            end
        end else if (w_res_valid) begin
            if (!r_out_valid || w_out_acc) begin
                r_out <= w_res;
            end else begin
                r_skid <= w_res;
            end
        end
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= KIND_SQUARE;
            r_open_limit  <= '1;
            r_close_limit <= '1;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_MODE:        r_mode        <= pwdata[1:0];
                REG_OPEN_LIMIT:  r_open_limit  <= pwdata[POS_W-1:0];
                REG_CLOSE_LIMIT: r_close_limit <= pwdata[POS_W-1:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        case (paddr[3:2])
            REG_MODE:        prdata = {30'd0, r_mode};
            REG_OPEN_LIMIT:  prdata = {{(32-POS_W){1'b0}}, r_open_limit};
            REG_CLOSE_LIMIT: prdata = {{(32-POS_W){1'b0}}, r_close_limit};
            default:         prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // skid holds a result only behind a waiting output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid occupied while output register empty");

    // fill count never passes the stack depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // every result ends the search
    a_res_ends_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |=> r_done)
        else $error("search still running after a result");

    // a push grows the stack by one
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> (r_count == $past(w_count_b) + CW'(1)))
        else $error("push did not grow the stack");

    // a found result only comes from a closer at the outermost level
    a_found_outermost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && (w_res.status == STATUS_FOUND)) |-> (w_count_b == CW'(1)))
        else $error("pair reported below the outermost level");

endmodule

// ----- test/tb_bracket_pair_locator.sv -----
// testbench for bracket_pair_locator: directed and random text streams against a predictor
`timescale 1ns / 1ps

module tb_bracket_pair_locator;
    import bpl_pkg::*;

    localparam int DEPTH        = 32;
    localparam int RAND_ITEMS   = 1300;
    localparam int DRAIN_CYCLES = 4;

    // clock, reset and block ports
    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_beat    i_in_data;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_beat   o_out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // predictor state and register copies
    logic [1:0]       open_kinds [DEPTH];
    int               nest;
    logic [POS_W-1:0] outer_pos;
    bit               halted;
    logic [1:0]       mode_r;
    logic [POS_W-1:0] open_lim_r;
    logic [POS_W-1:0] close_lim_r;

    // expected pair reports, oldest first
    t_out_beat pair_reports [$];
    int        errors;
    int        live_beats;
    bit        rush_in;
    bit        rush_out;
    int        rx_wait;

    bracket_pair_locator #(.STACK_DEPTH(DEPTH)) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // bracket kind of a byte; is_open tells opener from closer
    function automatic logic [1:0] classify(input logic [7:0] ch, output bit is_open);
        logic [1:0] k;
        is_open = 1'b0;
        case (ch)
            CH_SQ_OPEN: begin
                is_open = 1'b1;
                k = KIND_SQUARE;
            end
            CH_RD_OPEN: begin
                is_open = 1'b1;
                k = KIND_ROUND;
            end
            CH_BR_OPEN: begin
                is_open = 1'b1;
                k = KIND_BRACE;
            end
            CH_SQ_CLOSE: k = KIND_SQUARE;
            CH_RD_CLOSE: k = KIND_ROUND;
            CH_BR_CLOSE: k = KIND_BRACE;
            default:     k = KIND_NONE;
        endcase
        return k;
    endfunction

    function automatic bit admitted(input logic [1:0] k);
        return (k != KIND_NONE) && (mode_r == MODE_ANY || mode_r == k);
    endfunction

    // advance the search by one beat; returns 1 when a report is due
    function automatic bit locate_step(input t_in_beat b, output t_out_beat r);
        logic [1:0] k;
        bit         is_open;
        r = '0;
        live_beats++;
        k = classify(b.character, is_open);
        if (b.first) begin
            nest = 0;
            outer_pos = '0;
            halted = 1'b0;
        end
        if (halted)
            return 1'b0;
        if (is_open && admitted(k) && b.position <= open_lim_r) begin
            if (nest >= DEPTH) begin
                halted = 1'b1;
                r.status = STATUS_OVERFLOW;
                return 1'b1;
            end
            if (nest == 0)
                outer_pos = b.position;
            open_kinds[nest] = k;
            nest++;
        end else if (!is_open && nest != 0 && admitted(k) && b.position <= close_lim_r &&
                     open_kinds[nest-1] == k) begin
            if (nest == 1) begin
                halted = 1'b1;
                r.status = STATUS_FOUND;
                r.start_pos = outer_pos;
                r.end_pos = b.position;
                return 1'b1;
            end
            nest--;
        end
        if (b.last) begin
            halted = 1'b1;
            r.status = STATUS_NOT_FOUND;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // predict on each accepted input beat, compare each accepted result beat
    always @(posedge i_clk) begin
        t_out_beat want;
        t_out_beat got;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                if (locate_step(i_in_data, want))
                    pair_reports.push_back(want);
            end
            if (o_out_valid && !i_out_stall) begin
                got = o_out_data;
                if (pair_reports.size() == 0) begin
                    $display("%0t: unexpected result beat status %0d start %0d end %0d",
                             $time, got.status, got.start_pos, got.end_pos);
                    errors++;
                end else begin
                    want = pair_reports.pop_front();
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                        errors++;
                    end
                    if (got.start_pos !== want.start_pos) begin
                        $display("%0t: start_pos expected %0d actual %0d",
                                 $time, want.start_pos, got.start_pos);
                        errors++;
                    end
                    if (got.end_pos !== want.end_pos) begin
                        $display("%0t: end_pos expected %0d actual %0d",
                                 $time, want.end_pos, got.end_pos);
                        errors++;
                    end
                end
            end
        end
    end

    // result side stall: a random hold-off after every taken beat, none while rush_out is set
    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall)
            rx_wait = rush_out ? 0 : $urandom_range(0, 13);
        if (rx_wait > 0) begin
            i_out_stall <= 1'b1;
            rx_wait--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // one character beat, after a random gap (none while rush_in is set); returns at the accepting edge
    task automatic send_char(input logic [7:0] ch, input logic [POS_W-1:0] pos,
                             input bit first_f, input bit last_f);
        int       gap;
        t_in_beat b;
        gap = rush_in ? 0 : $urandom_range(0, 13);
        b.character = ch;
        b.position = pos;
        b.first = first_f;
        b.last = last_f;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= b;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // stop sending and let every expected report come out
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pair_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // register write, then read back
    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] mask;
        mask = (idx == REG_MODE) ? 32'h3 : 32'hFFFF;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_MODE:       mode_r = value[1:0];
            REG_OPEN_LIMIT: open_lim_r = value[POS_W-1:0];
            default:        close_lim_r = value[POS_W-1:0];
        endcase
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if ((prdata & mask) !== (value & mask)) begin
            $display("%0t: register %0d read expected %0h actual %0h",
                     $time, idx, value & mask, prdata & mask);
            errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [7:0] bracket_char(input logic [1:0] k, input bit is_open);
        case (k)
            KIND_ROUND: return is_open ? CH_RD_OPEN : CH_RD_CLOSE;
            KIND_BRACE: return is_open ? CH_BR_OPEN : CH_BR_CLOSE;
            default:    return is_open ? CH_SQ_OPEN : CH_SQ_CLOSE;
        endcase
    endfunction

    // mostly the enabled kind, sometimes any kind
    function automatic logic [1:0] pick_kind();
        if (mode_r == MODE_ANY || $urandom_range(0, 4) == 0)
            return 2'($urandom_range(0, 2));
        return mode_r;
    endfunction

    function automatic logic [POS_W-1:0] pick_limit();
        int r;
        r = $urandom_range(0, 19);
        if (r < 9)
            return '1;
        if (r < 12)
            return '0;
        return POS_W'($urandom_range(0, 30));
    endfunction

    // one string: mostly bracket text with a first and a last beat, some noise
    task automatic send_text();
        int               shape;
        int               len;
        int               opens;
        int               r;
        logic [POS_W-1:0] pos;
        logic [1:0]       open_trail [$];
        logic [1:0]       k;
        logic [7:0]       ch;
        bit               scatter;
        bit               lead;
        bit               tail;
        shape = $urandom_range(0, 19);
        lead = $urandom_range(0, 19) != 0;
        tail = $urandom_range(0, 9) != 0;
        scatter = $urandom_range(0, 9) == 0;
        r = $urandom_range(0, 19);
        if (r < 14)
            pos = '0;
        else if (r < 17)
            pos = POS_W'($urandom);
        else
            pos = '1 - POS_W'($urandom_range(0, 20));
        // noise: raw bytes with random flags
        if (shape == 0) begin
            len = $urandom_range(1, 8);
            repeat (len)
                send_char(8'($urandom_range(0, 255)), POS_W'($urandom),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            return;
        end
        // deep nesting runs the stack up to and past full
        opens = (shape <= 2) ? $urandom_range(DEPTH - 3, DEPTH + 4) : 0;
        len = opens + $urandom_range(1, 20);
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (i < opens || r < 40) begin
                k = pick_kind();
                open_trail.push_back(k);
                ch = bracket_char(k, 1'b1);
            end else if (r < 80) begin
                if (open_trail.size() != 0 && r < 70)
                    k = open_trail.pop_back();
                else
                    k = pick_kind();
                ch = bracket_char(k, 1'b0);
            end else begin
                ch = 8'($urandom_range(0, 255));
            end
            send_char(ch, scatter ? POS_W'($urandom) : pos, i == 0 && lead,
                      i == len - 1 && tail);
            pos++;
        end
    endtask

    // reset defaults, no first beat after reset, pair on the last beat, byte extremes
    task automatic test_reset_defaults();
        send_char(CH_SQ_OPEN, 16'd0, 1'b0, 1'b0);
        send_char(CH_RD_OPEN, 16'd1, 1'b0, 1'b0);
        send_char(CH_RD_CLOSE, 16'd2, 1'b0, 1'b0);
        send_char(8'hFF, 16'd3, 1'b0, 1'b0);
        send_char(8'h00, 16'd4, 1'b0, 1'b0);
        send_char(CH_SQ_CLOSE, 16'hFFFF, 1'b0, 1'b1);
        // search finished: ignored until the next first beat
        send_char(CH_SQ_OPEN, 16'd5, 1'b0, 1'b0);
        send_char(CH_SQ_CLOSE, 16'd6, 1'b0, 1'b1);
    endtask

    // unbalanced string and a single beat that is both first and last
    task automatic test_not_found();
        send_char(CH_SQ_OPEN, 16'd9, 1'b1, 1'b0);
        send_char(CH_SQ_OPEN, 16'd10, 1'b0, 1'b0);
        send_char(CH_SQ_CLOSE, 16'd11, 1'b0, 1'b0);
        send_char(CH_BR_CLOSE, 16'd12, 1'b0, 1'b1);
        send_char(CH_SQ_OPEN, 16'd0, 1'b1, 1'b1);
    endtask

    // open limit at zero and at its maximum, close limit at its maximum and below a closer
    task automatic test_limits();
        settle();
        cfg_write(REG_MODE, 32'(KIND_ROUND));
        cfg_write(REG_OPEN_LIMIT, 32'd0);
        cfg_write(REG_CLOSE_LIMIT, 32'hFFFF);
        send_char(CH_RD_OPEN, 16'd0, 1'b1, 1'b0);
        send_char(CH_RD_OPEN, 16'd1, 1'b0, 1'b0);
        send_char(CH_RD_CLOSE, 16'd2, 1'b0, 1'b0);
        settle();
        cfg_write(REG_MODE, 32'(KIND_BRACE));
        cfg_write(REG_OPEN_LIMIT, 32'hFFFF);
        cfg_write(REG_CLOSE_LIMIT, 32'd4);
        send_char(CH_BR_OPEN, 16'd3, 1'b1, 1'b0);
        send_char(CH_BR_CLOSE, 16'd9, 1'b0, 1'b0);
        send_char(CH_BR_CLOSE, 16'd4, 1'b0, 1'b1);
    endtask

    // all kinds at once, with mismatched closers skipped
    task automatic test_mixed_kinds();
        settle();
        cfg_write(REG_MODE, 32'(MODE_ANY));
        cfg_write(REG_CLOSE_LIMIT, 32'hFFFF);
        send_char(CH_BR_OPEN, 16'd0, 1'b1, 1'b0);
        send_char(CH_RD_OPEN, 16'd1, 1'b0, 1'b0);
        send_char(CH_BR_CLOSE, 16'd2, 1'b0, 1'b0);
        send_char(CH_RD_CLOSE, 16'd3, 1'b0, 1'b0);
        send_char(CH_SQ_CLOSE, 16'd4, 1'b0, 1'b0);
        send_char(CH_BR_CLOSE, 16'd5, 1'b0, 1'b0);
    endtask

    // random strings in phases of random settings
    task automatic test_random_streams();
        int beats_base;
        int strings_left;
        beats_base = live_beats;
        strings_left = 0;
        while (live_beats - beats_base < RAND_ITEMS) begin
            if (strings_left == 0) begin
                settle();
                cfg_write(REG_MODE, $urandom_range(0, 3));
                cfg_write(REG_OPEN_LIMIT, 32'(pick_limit()));
                cfg_write(REG_CLOSE_LIMIT, 32'(pick_limit()));
                strings_left = $urandom_range(8, 20);
            end
            if ($urandom_range(0, 7) == 0)
                rush_in = !rush_in;
            if ($urandom_range(0, 7) == 0)
                rush_out = !rush_out;
            send_text();
            strings_left--;
        end
    endtask

    initial begin
        int waited;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        mode_r = KIND_SQUARE;
        open_lim_r = '1;
        close_lim_r = '1;
        nest = 0;
        outer_pos = '0;
        halted = 1'b0;
        errors = 0;
        live_beats = 0;
        rush_in = 1'b0;
        rush_out = 1'b0;
        rx_wait = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_not_found();
        test_limits();
        test_mixed_kinds();
        test_random_streams();

        // drain with a bound, then allow for stray results
        i_in_valid <= 1'b0;
        waited = 0;
        @(posedge i_clk);
        while (pair_reports.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        if (pair_reports.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pair_reports.size());
            errors++;
        end
        repeat (DRAIN_CYCLES * 4) @(posedge i_clk);
        if (errors == 0)
            $display("** bracket_pair_locator: PASSED **");
        else
            $display("** bracket_pair_locator: FAILED **");
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("%0t: timeout", $time);
        $display("** bracket_pair_locator: FAILED **");
        $finish;
    end

endmodule
